// File: design/mwm_pkg.sv
// Package for the mecanum wheel mixer: widths, register indexes and the
// struct handed from cell to cell along the divider chain. No dependencies.
package mwm_pkg;

  localparam int FRAC_BITS = 14;
  localparam int AXIS_W    = 16;
  localparam int CMD_W     = 16;
  localparam int REG_W     = 15;
  localparam int NUM_WHEEL = 4;
  localparam int MIX_W     = AXIS_W + 2;
  localparam int MAG_W     = MIX_W - 1;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int DIV_W     = (FRAC_BITS + 1 > MAG_W) ? FRAC_BITS + 1 : MAG_W;
  localparam int REM_W     = DIV_W + 1;
  localparam int NUM_CELL  = QUO_W;

  localparam logic [DIV_W-1:0] ONE_Q = DIV_W'(1) << FRAC_BITS;

  localparam logic REG_DEADBAND = 1'b0;
  localparam logic REG_SPIN     = 1'b1;

  localparam logic [REG_W-1:0] DEADBAND_RST = REG_W'(4915);
  localparam logic [REG_W-1:0] SPIN_RST     = REG_W'(14746);

  typedef struct packed {
    logic                                vld;
    logic [DIV_W-1:0]                    div;
    logic [NUM_WHEEL-1:0]                neg;
    logic [NUM_WHEEL-1:0][REM_W-1:0]     rem;
    logic [NUM_WHEEL-1:0][QUO_W-1:0]     quo;
  } mwm_cell_t;

endpackage

// File: design/mwm_mix.sv
// Front of the mixer: deadband, wheel mix, then magnitudes and the divisor.
// Depends on mwm_pkg.
module mwm_mix (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              vld_i,
  input  logic signed [mwm_pkg::AXIS_W-1:0] stick_x_i,
  input  logic signed [mwm_pkg::AXIS_W-1:0] stick_y_i,
  input  logic signed [mwm_pkg::AXIS_W-1:0] stick_throttle_i,
  input  logic [mwm_pkg::REG_W-1:0]         deadband_i,
  input  logic [mwm_pkg::REG_W-1:0]         spin_magnitude_i,
  output mwm_pkg::mwm_cell_t                cell_o
);
  import mwm_pkg::*;

  logic signed [MIX_W-1:0] x_s, y_s, t_s, fwd, rgt, rot;
  logic [MIX_W-1:0] mag_x, mag_y, mag_t, db_ext;
  logic signed [MIX_W-1:0] w_d [NUM_WHEEL];
  logic signed [MIX_W-1:0] w_q [NUM_WHEEL];
  logic vld_a_q;
  logic [MAG_W-1:0] mag_w [NUM_WHEEL];
  logic [MAG_W-1:0] max01, max23, mx;
  mwm_cell_t cell_d, cell_q;

  always_comb begin
    x_s    = MIX_W'(stick_x_i);
    y_s    = MIX_W'(stick_y_i);
    t_s    = MIX_W'(stick_throttle_i);
    mag_x  = x_s < 0 ? -x_s : x_s;
    mag_y  = y_s < 0 ? -y_s : y_s;
    mag_t  = t_s < 0 ? -t_s : t_s;
    db_ext = MIX_W'(deadband_i);
    rgt    = (mag_x < db_ext) ? '0 : -x_s;
    fwd    = (mag_y < db_ext) ? '0 : -y_s;
    if (mag_t < db_ext || t_s == 0) begin
      rot = '0;
    end else if (t_s < 0) begin
      rot = -MIX_W'(spin_magnitude_i);
    end else begin
      rot = MIX_W'(spin_magnitude_i);
    end
    w_d[0] = fwd - rot + rgt;
    w_d[1] = fwd + rot - rgt;
    w_d[2] = fwd - rot - rgt;
    w_d[3] = fwd + rot + rgt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NUM_WHEEL; i++) begin
        w_q[i] <= w_d[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_WHEEL; i++) begin
      mag_w[i] = w_q[i] < 0 ? MAG_W'(-w_q[i]) : MAG_W'(w_q[i]);
    end
    max01 = (mag_w[1] > mag_w[0]) ? mag_w[1] : mag_w[0];
    max23 = (mag_w[3] > mag_w[2]) ? mag_w[3] : mag_w[2];
    mx    = (max23 > max01) ? max23 : max01;
    cell_d.vld = vld_a_q;
    cell_d.div = (DIV_W'(mx) > ONE_Q) ? DIV_W'(mx) : ONE_Q;
    for (int i = 0; i < NUM_WHEEL; i++) begin
      cell_d.neg[i] = w_q[i] < 0;
      cell_d.rem[i] = REM_W'(mag_w[i]);
      cell_d.quo[i] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// File: design/mwm_div_cell.sv
// One restoring-division cell: produces one quotient bit for all four wheels.
// Depends on mwm_pkg.
module mwm_div_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  mwm_pkg::mwm_cell_t cell_i,
  output mwm_pkg::mwm_cell_t cell_o
);
  import mwm_pkg::*;

  mwm_cell_t cell_d, cell_q;
  logic [REM_W-1:0] diff;
  logic             ge;

  always_comb begin
    cell_d = cell_i;
    diff   = '0;
    ge     = 1'b0;
    for (int i = 0; i < NUM_WHEEL; i++) begin
      ge   = cell_i.rem[i] >= REM_W'(cell_i.div);
      diff = ge ? cell_i.rem[i] - REM_W'(cell_i.div) : cell_i.rem[i];
      cell_d.rem[i] = {diff[REM_W-2:0], 1'b0};
      cell_d.quo[i] = {cell_i.quo[i][QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// File: design/mecanum_wheel_mixer_top.sv
// Mecanum wheel mixer top level: config registers, mixer front, division
// cell chain and output register. Depends on mwm_pkg, mwm_mix, mwm_div_cell.
// Pipeline: two mix stages, one cell per quotient bit, FRAC_BITS + 1
// cells, and the output register.
// Throughput: one item per cycle; the whole chain advances together and
// holds while an output item waits unaccepted.
// Reset: asynchronous, clears all valid flags and loads the register resets.
module mecanum_wheel_mixer_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // stick_x [15:0], stick_y [31:16], stick_throttle [47:32]
  input  logic [3*mwm_pkg::AXIS_W-1:0] s_axis_tdata_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // front_left_cmd [15:0], front_right_cmd [31:16], rear_left_cmd [47:32],
  // rear_right_cmd [63:48]
  output logic [4*mwm_pkg::CMD_W-1:0] m_axis_tdata_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [mwm_pkg::REG_W-1:0] cfg_data_i
);
  import mwm_pkg::*;

  logic [REG_W-1:0] deadband_q, spin_q;
  logic             en;
  logic             m_vld_q;
  logic [NUM_WHEEL*CMD_W-1:0] m_data_d, m_data_q;
  logic signed [QUO_W:0] res;
  mwm_cell_t chain [NUM_CELL+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q <= DEADBAND_RST;
      spin_q     <= SPIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEADBAND: deadband_q <= cfg_data_i;
        REG_SPIN:     spin_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en              = !m_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  mwm_mix u_mix (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (en),
    .vld_i            (s_axis_tvalid_i),
    .stick_x_i        (s_axis_tdata_i[AXIS_W-1:0]),
    .stick_y_i        (s_axis_tdata_i[2*AXIS_W-1:AXIS_W]),
    .stick_throttle_i (s_axis_tdata_i[3*AXIS_W-1:2*AXIS_W]),
    .deadband_i       (deadband_q),
    .spin_magnitude_i (spin_q),
    .cell_o           (chain[0])
  );

  for (genvar g = 0; g < NUM_CELL; g++) begin : g_cell
    mwm_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  always_comb begin
    m_data_d = '0;
    res      = '0;
    for (int i = 0; i < NUM_WHEEL; i++) begin
      res = signed'({1'b0, chain[NUM_CELL].quo[i]});
      if (chain[NUM_CELL].neg[i] ^ (i == 1 || i == 3)) begin
        res = -res;
      end
      m_data_d[i*CMD_W +: CMD_W] = CMD_W'(res);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q <= chain[NUM_CELL].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for mecanum_wheel_mixer_top: a directed table, then random
// joystick items under several register settings, checked against a local predictor.
// Depends on mwm_pkg and the mixer RTL.
`timescale 1ns / 100ps

module tb_top;
  import mwm_pkg::*;

  localparam int LATENCY         = 18;
  localparam int LIMIT           = 200000;
  localparam int LONG_HOLD       = 150;
  localparam int NUM_DIR         = 26;
  localparam int NUM_PHASE       = 6;
  localparam int ITEMS_PER_PHASE = 65;

  typedef logic [NUM_WHEEL*CMD_W-1:0] cmd_t;
  typedef logic [3*AXIS_W-1:0] axes_t;
  typedef enum logic [1:0] {ROW_CFG, ROW_CHECK, ROW_PREDICT} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic             reg_idx;
    logic [REG_W-1:0] reg_val;
    axes_t            axes;
    cmd_t             cmd;
  } stim_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             s_valid;
  logic             s_ready;
  axes_t            s_data;
  logic             m_valid;
  logic             m_ready;
  cmd_t             m_data;
  logic             cfg_we;
  logic             cfg_idx;
  logic [REG_W-1:0] cfg_data;

  logic [REG_W-1:0] cur_deadband;
  logic [REG_W-1:0] cur_spin;
  cmd_t             pending_cmds[$];
  stim_row_t        dir_tab [NUM_DIR];
  string            wheel_name [NUM_WHEEL] = '{"front_left_cmd", "front_right_cmd",
                                               "rear_left_cmd", "rear_right_cmd"};
  int               fail_cnt = 0;
  int               cycle_cnt = 0;
  bit               idle_on = 1'b1;
  bit               hold_outputs = 1'b0;

  mecanum_wheel_mixer_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  always #10 clk_i = ~clk_i;

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic cmd_t predict_wheel_cmds(input axes_t axes);
    longint x, y, t, db, spin, fwd, rgt, rot, peak, one;
    longint w [NUM_WHEEL];
    cmd_t res;
    x    = longint'($signed(axes[AXIS_W-1:0]));
    y    = longint'($signed(axes[2*AXIS_W-1:AXIS_W]));
    t    = longint'($signed(axes[3*AXIS_W-1:2*AXIS_W]));
    db   = longint'(cur_deadband);
    spin = longint'(cur_spin);
    one  = longint'(1) << FRAC_BITS;
    fwd  = (mag(y) < db) ? 0 : -y;
    rgt  = (mag(x) < db) ? 0 : -x;
    if (mag(t) < db || t == 0) begin
      rot = 0;
    end else begin
      rot = (t < 0) ? -spin : spin;
    end
    w[0] = fwd - rot + rgt;
    w[1] = fwd + rot - rgt;
    w[2] = fwd - rot - rgt;
    w[3] = fwd + rot + rgt;
    peak = 0;
    for (int i = 0; i < NUM_WHEEL; i++) begin
      if (mag(w[i]) > peak) begin
        peak = mag(w[i]);
      end
    end
    for (int i = 0; i < NUM_WHEEL; i++) begin
      if (peak > one) begin
        w[i] = (w[i] * one) / peak;
      end
      res[i*CMD_W +: CMD_W] = CMD_W'((i % 2 == 1) ? -w[i] : w[i]);
    end
    return res;
  endfunction

  function automatic stim_row_t chk(input int x, y, t, fl, fr, rl, rr);
    stim_row_t r;
    r.kind    = ROW_CHECK;
    r.reg_idx = REG_DEADBAND;
    r.reg_val = '0;
    r.axes    = {16'(t), 16'(y), 16'(x)};
    r.cmd     = {16'(rr), 16'(rl), 16'(fr), 16'(fl)};
    return r;
  endfunction

  function automatic stim_row_t pred(input int x, y, t);
    stim_row_t r;
    r.kind    = ROW_PREDICT;
    r.reg_idx = REG_DEADBAND;
    r.reg_val = '0;
    r.axes    = {16'(t), 16'(y), 16'(x)};
    r.cmd     = '0;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic idx, input int val);
    stim_row_t r;
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = REG_W'(val);
    r.axes    = '0;
    r.cmd     = '0;
    return r;
  endfunction

  function automatic logic [AXIS_W-1:0] rand_axis();
    int v;
    case ($urandom_range(0, 7))
      0, 1: v = int'($urandom_range(0, 65535));
      2, 3, 4: v = int'($urandom_range(0, 32768)) - 16384;
      5: begin
        v = int'(cur_deadband) + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1) == 1) begin
          v = -v;
        end
      end
      6: v = 0;
      default: begin
        case ($urandom_range(0, 3))
          0: v = -32768;
          1: v = 32767;
          2: v = 16384;
          default: v = -16384;
        endcase
      end
    endcase
    return AXIS_W'(v);
  endfunction

  task automatic write_reg(input logic idx, input logic [REG_W-1:0] val);
    s_valid <= 1'b0;
    while (pending_cmds.size() != 0) begin
      @(posedge clk_i);
    end
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_DEADBAND) begin
      cur_deadband = val;
    end else begin
      cur_spin = val;
    end
  endtask

  task automatic send_item(input axes_t axes, input bit typed, input cmd_t typed_cmd);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= axes;
    @(posedge clk_i);
    while (!s_ready) begin
      @(posedge clk_i);
    end
    pending_cmds.push_back(typed ? typed_cmd : predict_wheel_cmds(axes));
  endtask

  initial begin
    logic [REG_W-1:0] db_val;
    logic [REG_W-1:0] spin_val;
    dir_tab = '{
      chk(0, 0, 0, 0, 0, 0, 0),
      chk(0, -16384, 0, 16384, -16384, 16384, -16384),
      chk(0, 16384, 0, -16384, 16384, -16384, 16384),
      chk(-16384, 0, 0, 16384, 16384, -16384, -16384),
      chk(0, 0, 16384, -14746, -14746, -14746, -14746),
      chk(0, 0, -16384, 14746, 14746, 14746, 14746),
      chk(4914, -4914, 4914, 0, 0, 0, 0),
      chk(4915, 0, 0, -4915, -4915, 4915, 4915),
      chk(-16384, -16384, 0, 16384, 0, 0, -16384),
      pred(-32768, -32768, -32768),
      pred(32767, 32767, 32767),
      pred(-16384, -16384, 16384),
      pred(12345, -8000, -5000),
      cfg_row(REG_DEADBAND, 0),
      chk(0, 0, 0, 0, 0, 0, 0),
      chk(0, 0, 1, -14746, -14746, -14746, -14746),
      pred(1, -1, -1),
      cfg_row(REG_SPIN, 32767),
      chk(0, 0, 100, -16384, -16384, -16384, -16384),
      pred(-32768, -32768, -32768),
      cfg_row(REG_SPIN, 0),
      chk(0, 0, 16384, 0, 0, 0, 0),
      pred(32767, -32768, 5),
      cfg_row(REG_DEADBAND, 16384),
      chk(16383, -16383, -16383, 0, 0, 0, 0),
      chk(16384, 0, 0, -16384, -16384, 16384, 16384)
    };
    cur_deadband = DEADBAND_RST;
    cur_spin     = SPIN_RST;
    rst_ni   <= 1'b0;
    s_valid  <= 1'b0;
    s_data   <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= REG_DEADBAND;
    cfg_data <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
      end else begin
        send_item(dir_tab[i].axes, dir_tab[i].kind == ROW_CHECK, dir_tab[i].cmd);
      end
    end

    for (int p = 0; p < NUM_PHASE; p++) begin
      case (p)
        0: begin
          db_val = '0;
          spin_val = '0;
        end
        1: begin
          db_val = 15'd16384;
          spin_val = 15'd16384;
        end
        2: begin
          db_val = DEADBAND_RST;
          spin_val = SPIN_RST;
        end
        3: begin
          db_val = '1;
          spin_val = '1;
        end
        default: begin
          db_val = REG_W'($urandom_range(0, 8000));
          spin_val = REG_W'($urandom_range(0, 32767));
        end
      endcase
      write_reg(REG_DEADBAND, db_val);
      write_reg(REG_SPIN, spin_val);
      idle_on = (p != NUM_PHASE - 1);
      if (p == 2) begin
        hold_outputs = 1'b1;
      end
      repeat (ITEMS_PER_PHASE) begin
        send_item({rand_axis(), rand_axis(), rand_axis()}, 1'b0, '0);
      end
    end

    s_valid <= 1'b0;
    while (pending_cmds.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (2 * LATENCY) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // The long hold-off lets the divider chain fill so the input side stalls.
  initial begin
    m_ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) begin
      @(posedge clk_i);
    end
    forever begin
      if (hold_outputs) begin
        m_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_outputs = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        m_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    cmd_t want;
    if (rst_ni && m_valid && m_ready) begin
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected output item, expected none, got %h", $time, m_data);
        fail_cnt++;
      end else begin
        want = pending_cmds.pop_front();
        for (int i = 0; i < NUM_WHEEL; i++) begin
          if (m_data[i*CMD_W +: CMD_W] !== want[i*CMD_W +: CMD_W]) begin
            $display("%0t: %s expected %0d, got %0d", $time, wheel_name[i],
                     $signed(want[i*CMD_W +: CMD_W]), $signed(m_data[i*CMD_W +: CMD_W]));
            fail_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
